/* sv/vdm_pkg.sv */
package vdm_pkg;

	localparam int ElemW = 16;
	localparam int AccW  = 41;
	localparam int OutW  = 33;
	localparam int RemW  = 33;
	localparam int RootW = 29;
	localparam int DenW  = 17;
	localparam int CntW  = 5;

	typedef logic [1:0] metric_t;

	localparam metric_t MetricEuclid    = 2'd0;
	localparam metric_t MetricManhattan = 2'd1;
	localparam metric_t MetricChebyshev = 2'd2;
	localparam metric_t MetricCanberra  = 2'd3;

	// First step index of each iterative operation; the counter runs down to zero.
	localparam logic [CntW-1:0] DivLast  = 5'd16;
	localparam logic [CntW-1:0] RootLast = 5'd28;

	typedef struct packed {
		logic [RemW-1:0] cand;
		logic [RemW-1:0] trial;
	} sub_op_t;

	typedef struct packed {
		logic            ge;
		logic [RemW-1:0] diff;
	} sub_res_t;

endpackage

/* sv/vdm_sub_unit.sv */
// Shared compare-and-subtract step for the divider and the square root.
module vdm_sub_unit (
	input  vdm_pkg::sub_op_t  op,
	output vdm_pkg::sub_res_t res
);

	assign res.ge   = (op.cand >= op.trial);
	assign res.diff = op.cand - op.trial;

endmodule

/* sv/vector_distance_metrics.sv */
// Vector distance unit. Element pairs (signed Q8.8) stream in on the slave side, s_tlast
// marking the final pair; on that pair the distance in unsigned Q.16 leaves on the master
// side and the running value clears. metric_mode selects Euclidean, Manhattan, Chebyshev or
// Canberra; the user must write it only while the block is idle, as the block does not
// enforce this itself. One compare-and-subtract unit, stepped by a small sequencer, does
// both the Canberra division and the Euclidean root. Each pair passes states ABS and ACC,
// with one multiply stage between them for Euclidean and 17 divide steps in the shared unit
// for Canberra (none when both elements are zero); no new pair is taken until the last is
// through. The final pair loads the output register in the result stage, after 29 root
// steps in the same unit for Euclidean. A result waiting in the output register does not
// block new pairs; the block holds only when a second result is ready before the first is taken.
module vector_distance_metrics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,  // metric_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // elem_a [15:0], elem_b [31:16]
	input  logic        s_tlast,      // last_elem
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata       // distance [32:0], zero [39:33]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_MUL,
		ST_DIV,
		ST_ACC,
		ST_ROOT,
		ST_FIN
	} state_t;

	state_t                          state_q;
	vdm_pkg::metric_t                mode_q;
	logic [vdm_pkg::ElemW-1:0]       a_q;
	logic [vdm_pkg::ElemW-1:0]       b_q;
	logic                            last_q;
	logic [vdm_pkg::ElemW-1:0]       ad_q;
	logic [vdm_pkg::DenW-1:0]        den_q;
	logic [31:0]                     add_q;
	logic [vdm_pkg::AccW-1:0]        rv_q;
	logic [vdm_pkg::RemW-1:0]        rem_q;
	logic [vdm_pkg::RootW-1:0]       quo_q;
	logic [57:0]                     rad_q;
	logic [vdm_pkg::CntW-1:0]        cnt_q;
	logic                            out_valid_q;
	logic [vdm_pkg::OutW-1:0]        out_data_q;

	logic [16:0]                     diff_ab;
	logic [vdm_pkg::ElemW-1:0]       abs_d;
	logic [vdm_pkg::ElemW-1:0]       abs_a;
	logic [vdm_pkg::ElemW-1:0]       abs_b;
	logic [vdm_pkg::DenW-1:0]        den;
	logic [31:0]                     prod;
	logic [vdm_pkg::AccW:0]          sum_wide;
	logic [vdm_pkg::AccW-1:0]        next_rv;
	logic [vdm_pkg::OutW-1:0]        result;
	logic                            out_free;
	vdm_pkg::sub_op_t                sub_op;
	vdm_pkg::sub_res_t               sub_res;
	logic [vdm_pkg::RootW-1:0]       quo_next;
	logic [vdm_pkg::RemW-1:0]        rem_next;

	assign diff_ab = {a_q[15], a_q} - {b_q[15], b_q};
	assign abs_d   = diff_ab[16] ? 16'(-diff_ab) : diff_ab[15:0];
	assign abs_a   = a_q[15] ? 16'(-a_q) : a_q;
	assign abs_b   = b_q[15] ? 16'(-b_q) : b_q;
	assign den     = {1'b0, abs_a} + {1'b0, abs_b};
	assign prod    = {16'b0, ad_q} * {16'b0, ad_q};

	assign sum_wide = {1'b0, rv_q} + {10'b0, add_q};

	always_comb begin
		case (mode_q)
			vdm_pkg::MetricChebyshev: begin
				next_rv = ({25'b0, ad_q} > rv_q) ? {25'b0, ad_q} : rv_q;
			end
			default: begin
				next_rv = sum_wide[vdm_pkg::AccW] ? {vdm_pkg::AccW{1'b1}}
				                                  : sum_wide[vdm_pkg::AccW-1:0];
			end
		endcase
	end

	always_comb begin
		case (mode_q)
			vdm_pkg::MetricEuclid: begin
				result = {4'b0, quo_q};
			end
			vdm_pkg::MetricCanberra: begin
				result = (rv_q[40:33] != 8'd0) ? {vdm_pkg::OutW{1'b1}} : rv_q[32:0];
			end
			default: begin
				result = (rv_q[40:25] != 16'd0) ? {vdm_pkg::OutW{1'b1}}
				                                : {rv_q[24:0], 8'b0};
			end
		endcase
	end

	// Root step brings down two radicand bits; divide step shifts the remainder by one
	// except on the first step, which yields the integer bit of the quotient.
	always_comb begin
		if (state_q == ST_ROOT) begin
			sub_op.cand  = {rem_q[30:0], rad_q[57:56]};
			sub_op.trial = {2'b0, quo_q, 2'b01};
		end else begin
			sub_op.cand  = (cnt_q == vdm_pkg::DivLast) ? rem_q : {rem_q[31:0], 1'b0};
			sub_op.trial = {16'b0, den_q};
		end
	end

	vdm_sub_unit u_sub (
		.op  (sub_op),
		.res (sub_res)
	);

	assign quo_next = {quo_q[vdm_pkg::RootW-2:0], sub_res.ge};
	assign rem_next = sub_res.ge ? sub_res.diff : sub_op.cand;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= vdm_pkg::MetricEuclid;
			a_q         <= '0;
			b_q         <= '0;
			last_q      <= 1'b0;
			ad_q        <= '0;
			den_q       <= '0;
			add_q       <= '0;
			rv_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			rad_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			// the result stage reloads the output register itself
			if (m_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						a_q     <= s_tdata[15:0];
						b_q     <= s_tdata[31:16];
						last_q  <= s_tlast;
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					ad_q  <= abs_d;
					den_q <= den;
					// a zero denominator means both elements are zero, so this adds nothing
					add_q <= {16'b0, abs_d};
					rem_q <= {17'b0, abs_d};
					quo_q <= '0;
					cnt_q <= vdm_pkg::DivLast;
					case (mode_q)
						vdm_pkg::MetricEuclid: begin
							state_q <= ST_MUL;
						end
						vdm_pkg::MetricCanberra: begin
							if (den == '0) begin
								state_q <= ST_ACC;
							end else begin
								state_q <= ST_DIV;
							end
						end
						default: begin
							state_q <= ST_ACC;
						end
					endcase
				end
				ST_MUL: begin
					add_q   <= prod;
					state_q <= ST_ACC;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						add_q   <= {15'b0, quo_next[16:0]};
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					rv_q  <= next_rv;
					rad_q <= {1'b0, next_rv, 16'b0};
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= vdm_pkg::RootLast;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (mode_q == vdm_pkg::MetricEuclid) begin
						state_q <= ST_ROOT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_ROOT: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					rad_q <= {rad_q[55:0], 2'b00};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register can take the result
					if (out_free) begin
						out_data_q  <= result;
						out_valid_q <= 1'b1;
						rv_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_data_q};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a pair is still in progress");

	a_root_ends_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && cnt_q == '0) |=> (state_q == ST_FIN))
		else $error("root sequence did not hand off to result stage");

	a_quotient_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (add_q <= 32'd65536))
		else $error("Canberra term above one");

	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free && mode_q == vdm_pkg::MetricEuclid)
		|=> (m_tdata[32:29] == 4'd0))
		else $error("Euclidean root wider than 29 bits");

endmodule

/* verif/tb_vector_distance_metrics.sv */
module tb_vector_distance_metrics;
	timeunit 1ns;
	timeprecision 1ps;

	import vdm_pkg::*;

	localparam int TargetPairs = 1750;
	localparam int QuietLimit  = 1000;
	// Longest stretch the block may keep working after a pair that yields no distance.
	localparam int SettleCycles = 48;
	localparam logic [63:0] AccMax = (64'd1 << AccW) - 64'd1;
	localparam logic [63:0] OutMax = (64'd1 << OutW) - 64'd1;

	class dist_scoreboard;
		logic [AccW-1:0] acc;
		metric_t         metric;
		logic [OutW-1:0] expected_q[$];
		int              mismatches;
		int              checked;

		function new();
			acc = '0;
			metric = MetricEuclid;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [AccW-1:0] clamp_acc(logic [63:0] sum);
			return (sum > AccMax) ? AccMax[AccW-1:0] : sum[AccW-1:0];
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] x);
			logic [63:0] root;
			logic [63:0] trial;
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= x) root = trial;
			end
			return root;
		endfunction

		function void note_pair(logic [15:0] ea, logic [15:0] eb, logic last);
			longint      va;
			longint      vb;
			longint      dif;
			logic [63:0] mag_d;
			logic [63:0] den;
			logic [63:0] term;
			logic [63:0] dist_val;
			va = longint'($signed(ea));
			vb = longint'($signed(eb));
			dif = va - vb;
			mag_d = (dif < 0) ? -dif : dif;
			den = ((va < 0) ? -va : va) + ((vb < 0) ? -vb : vb);
			case (metric)
				MetricEuclid: acc = clamp_acc({23'd0, acc} + mag_d * mag_d);
				MetricManhattan: acc = clamp_acc({23'd0, acc} + mag_d);
				MetricChebyshev: begin
					if (mag_d > {23'd0, acc}) acc = mag_d[AccW-1:0];
				end
				default: begin
					// a zero denominator contributes nothing
					term = (den == 0) ? 64'd0 : ((mag_d << 16) / den);
					acc = clamp_acc({23'd0, acc} + term);
				end
			endcase
			if (!last) return;
			case (metric)
				MetricEuclid: dist_val = int_sqrt({7'd0, acc, 16'd0});
				MetricManhattan, MetricChebyshev: dist_val = {15'd0, acc, 8'd0};
				default: dist_val = {23'd0, acc};
			endcase
			if (dist_val > OutMax) dist_val = OutMax;
			expected_q.push_back(dist_val[OutW-1:0]);
			acc = '0;
		endfunction

		function void check_distance(logic [39:0] got);
			logic [39:0] want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: distance 0x%0h arrived with no vector pending", $realtime, got);
				return;
			end
			want = {7'd0, expected_q.pop_front()};
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: distance mismatch (metric %0d): expected 0x%0h, got 0x%0h",
						$realtime, metric, want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	metric_t     cfg_wr_data = MetricEuclid;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // elem_a [15:0], elem_b [31:16]
	logic        s_tlast = 1'b0;   // last_elem
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // distance [32:0], zero [39:33]

	dist_scoreboard sb;
	bit gaps_on;
	int pairs_sent;
	int quiet_cycles = 0;
	int ready_hold = 0;

	vector_distance_metrics dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: check each transfer, stall in short random bursts while gaps are on.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_distance(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("%0t: no transfer for %0d cycles", $realtime, QuietLimit);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [15:0] pick_elem();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7fff;
			2: v = 16'h0000;
			3: begin
				v = 16'($urandom_range(0, 600));
				v = v - 16'd300;
			end
			default: v = 16'($urandom_range(0, 16'hffff));
		endcase
		return v;
	endfunction

	task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pair(a, b, last);
		pairs_sent++;
	endtask

	task automatic send_random_pair(input logic last);
		logic [15:0] a;
		logic [15:0] b;
		a = pick_elem();
		case ($urandom_range(0, 7))
			0: b = a;
			1: b = -a;
			default: b = pick_elem();
		endcase
		send_pair(a, b, last);
	endtask

	// Hold the sender until every distance is back and the block has gone quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic switch_metric(input metric_t m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.metric = m;
	endtask

	initial begin
		metric_t m;
		int nvec;
		int len;
		sb = new();
		gaps_on = 1'b1;
		pairs_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		switch_metric(MetricEuclid);
		send_pair(16'h7fff, 16'h8000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		switch_metric(MetricManhattan);
		send_pair(16'h8000, 16'h7fff, 1'b0);
		send_pair(16'h0001, 16'hffff, 1'b1);
		switch_metric(MetricChebyshev);
		send_pair(16'h0005, 16'h0003, 1'b0);
		send_pair(16'h8000, 16'h7fff, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b1);
		switch_metric(MetricCanberra);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'h8000, 16'h7fff, 1'b0);
		send_pair(16'h0064, 16'hff9c, 1'b0);
		send_pair(16'h0100, 16'h0080, 1'b0);
		send_pair(16'h0000, 16'hffff, 1'b1);
		// metric changes inside a vector, driving the distance into saturation
		switch_metric(MetricEuclid);
		repeat (3) send_pair(16'h7fff, 16'h8000, 1'b0);
		switch_metric(MetricCanberra);
		send_pair(16'h0000, 16'h0000, 1'b1);
		switch_metric(MetricEuclid);
		send_pair(16'h7fff, 16'h8000, 1'b0);
		switch_metric(MetricManhattan);
		send_pair(16'h0001, 16'hffff, 1'b1);

		// long vector of worst-case pairs saturates the running sum
		switch_metric(MetricEuclid);
		repeat (520) send_pair(16'h7fff, 16'h8000, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b1);

		while (pairs_sent < TargetPairs) begin
			m = metric_t'($urandom_range(0, 3));
			switch_metric(m);
			gaps_on = (pairs_sent < TargetPairs - 250) && ($urandom_range(0, 3) != 0);
			nvec = $urandom_range(1, 6);
			repeat (nvec) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				for (int k = 1; k <= len; k++) send_random_pair(k == len);
			end
			// leave a partial vector to carry into the next metric
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_random_pair(1'b0);
		end
		drain();

		$display("Sent %0d element pairs and checked %0d distances over all four metrics,",
			pairs_sent, sb.checked);
		$display("with extreme elements, zero denominators, saturation and mid-vector switches.");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
